// ----- sv/gbs_pkg.sv -----
// Shared constants for the blocked-grid spread core.
package gbs_pkg;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  localparam int ROW_W       = 64;  // width of the row mask ports
  localparam int ROW_NUM_W   = 6;
  localparam int PERIOD_W    = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;

  localparam logic [CFG_DATA_W-1:0] GRID_ROWS_RST = 7'd64;
  localparam logic [CFG_DATA_W-1:0] GRID_COLS_RST = 7'd64;

  // request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_RUN  = 1'b1;

endpackage

// ----- sv/gbs_row_mem.sv -----
// Row store: infected and blocked masks, one read and one write port, registered read.
module gbs_row_mem #(
  parameter int ROWS = 64,
  parameter int COLS = 64,
  parameter int AW   = 6
) (
  input  logic            clk,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output logic [COLS-1:0] rd_inf,
  output logic [COLS-1:0] rd_blk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  logic [COLS-1:0] wr_inf,
  input  logic [COLS-1:0] wr_blk
);

  logic [COLS-1:0] inf_mem [ROWS];
  logic [COLS-1:0] blk_mem [ROWS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      inf_mem[wr_addr] <= wr_inf;
      blk_mem[wr_addr] <= wr_blk;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_inf <= inf_mem[rd_addr];
      rd_blk <= blk_mem[rd_addr];
    end
  end

endmodule

// ----- sv/grid_blocked_spread_step_core.sv -----
// Blocked-grid spread core: row loader, per-period row walk and result emitter.
//
// A load item (in_req_type = 0) writes the next grid row and leaves busy low, so loads may
// follow each other every cycle. A run item (in_req_type = 1) raises busy while it walks W
// spread periods and then emits the grid, where W is the number of spread periods actually
// walked: at most in_period_count, fewer once a period leaves the grid unchanged. Each
// period is one walk over the row memory through its single read port, keeping a three-row
// window in registers. The grid is then returned one row per cycle on out_valid, rows in
// order, out_last_row on the final one; the receiver cannot stall, so every row is shown
// for exactly one cycle. The last row is shown in the first cycle in which busy is low again.
module grid_blocked_spread_step_core #(
  parameter int MAX_ROWS = gbs_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = gbs_pkg::DEF_MAX_COLS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // command channel
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_req_type,
  input  logic [gbs_pkg::ROW_W-1:0]      in_row_infected_in,
  input  logic [gbs_pkg::ROW_W-1:0]      in_row_blocked_in,
  input  logic [gbs_pkg::PERIOD_W-1:0]   in_period_count,
  // result channel
  output logic                           out_valid,
  output logic [gbs_pkg::ROW_NUM_W-1:0]  out_row_number,
  output logic [gbs_pkg::ROW_W-1:0]      out_row_infected_out,
  output logic [gbs_pkg::ROW_W-1:0]      out_row_blocked_out,
  output logic                           out_last_row,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gbs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gbs_pkg::*;

  localparam int RW = $clog2(MAX_ROWS);      // row index
  localparam int SW = $clog2(MAX_ROWS + 2);  // walk step, up to rows + 1

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SPREAD = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [SW-1:0]         step_r, step_nxt;
  logic [PERIOD_W-1:0]   per_r, per_nxt;
  logic                  chg_r, chg_nxt;
  logic [RW-1:0]         lp_r, lp_nxt;
  logic [CFG_DATA_W-1:0] grid_rows_r, grid_cols_r;

  logic [MAX_COLS-1:0]   w_prev_r, w_prev_nxt;
  logic [MAX_COLS-1:0]   w_mid_r, w_mid_nxt;
  logic [MAX_COLS-1:0]   w_blk_r, w_blk_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [RW-1:0]         out_row_r, out_row_nxt;
  logic [MAX_COLS-1:0]   out_inf_r, out_inf_nxt;
  logic [MAX_COLS-1:0]   out_blk_r, out_blk_nxt;

  logic [SW-1:0]         rows_eff;
  logic [CFG_DATA_W-1:0] cols_eff;
  logic [MAX_COLS-1:0]   col_mask;

  logic                  rd_en, wr_en;
  logic [RW-1:0]         rd_addr, wr_addr;
  logic [MAX_COLS-1:0]   rd_inf, rd_blk, rd_inf_n, rd_blk_n;
  logic [MAX_COLS-1:0]   wr_inf, wr_blk;

  logic [MAX_COLS-1:0]   down, spread, row_nxt;
  logic                  row_chg, chg_all;
  logic [MAX_COLS-1:0]   ld_blk, ld_inf;
  logic [RW-1:0]         ld_idx;
  logic [SW-1:0]         ld_inc;
  logic                  accept;

  gbs_row_mem #(
    .ROWS (MAX_ROWS),
    .COLS (MAX_COLS),
    .AW   (RW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_inf  (rd_inf),
    .rd_blk  (rd_blk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_inf  (wr_inf),
    .wr_blk  (wr_blk)
  );

  // effective geometry: zero acts as one, anything above the maximum as the maximum
  always_comb begin
    if (grid_rows_r == '0) begin
      rows_eff = SW'(1);
    end else if (grid_rows_r > CFG_DATA_W'(MAX_ROWS)) begin
      rows_eff = SW'(MAX_ROWS);
    end else begin
      rows_eff = SW'(grid_rows_r);
    end
    if (grid_cols_r == '0) begin
      cols_eff = CFG_DATA_W'(1);
    end else if (grid_cols_r > CFG_DATA_W'(MAX_COLS)) begin
      cols_eff = CFG_DATA_W'(MAX_COLS);
    end else begin
      cols_eff = grid_cols_r;
    end
    for (int j = 0; j < MAX_COLS; j++) begin
      col_mask[j] = CFG_DATA_W'(j) < cols_eff;
    end
  end

  // rows as read back, cut to the columns in use; blocked wins over infected
  assign rd_blk_n = rd_blk & col_mask;
  assign rd_inf_n = rd_inf & col_mask & ~rd_blk_n;

  // one period update of the row in the middle of the window
  assign down    = (step_r <= rows_eff) ? rd_inf_n : '0;
  assign spread  = w_mid_r | (w_mid_r << 1) | (w_mid_r >> 1) | w_prev_r | down;
  assign row_nxt = (w_mid_r | (spread & ~w_blk_r)) & col_mask;
  assign row_chg = row_nxt != w_mid_r;
  assign chg_all = chg_r | row_chg;

  assign ld_blk = in_row_blocked_in[MAX_COLS-1:0] & col_mask;
  assign ld_inf = in_row_infected_in[MAX_COLS-1:0] & col_mask & ~ld_blk;
  assign ld_idx = (SW'(lp_r) >= rows_eff) ? '0 : lp_r;
  assign ld_inc = SW'(ld_idx) + SW'(1);

  assign accept = start && (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    per_nxt       = per_r;
    chg_nxt       = chg_r;
    lp_nxt        = lp_r;
    w_prev_nxt    = w_prev_r;
    w_mid_nxt     = w_mid_r;
    w_blk_nxt     = w_blk_r;
    out_valid_nxt = 1'b0;
    out_last_nxt  = out_last_r;
    out_row_nxt   = out_row_r;
    out_inf_nxt   = out_inf_r;
    out_blk_nxt   = out_blk_r;
    rd_en         = step_r < rows_eff;
    rd_addr       = step_r[RW-1:0];
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_inf        = '0;
    wr_blk        = '0;

    case (state_r)
      ST_IDLE: begin
        rd_en = 1'b0;
        if (accept) begin
          if (in_req_type == REQ_RUN) begin
            lp_nxt   = '0;
            step_nxt = '0;
            chg_nxt  = 1'b0;
            per_nxt  = in_period_count;
            state_nxt = (in_period_count == '0) ? ST_EMIT : ST_SPREAD;
          end else begin
            wr_en   = 1'b1;
            wr_addr = ld_idx;
            wr_inf  = ld_inf;
            wr_blk  = ld_blk;
            lp_nxt  = (ld_inc >= rows_eff) ? '0 : ld_inc[RW-1:0];
          end
        end
      end

      ST_SPREAD: begin
        if (step_r == '0) begin
          w_mid_nxt = '0;
          chg_nxt   = 1'b0;
        end else begin
          w_prev_nxt = w_mid_r;
          w_mid_nxt  = rd_inf_n;
          w_blk_nxt  = rd_blk_n;
        end
        if (step_r >= SW'(2)) begin
          wr_en   = 1'b1;
          wr_addr = RW'(step_r - SW'(2));
          wr_inf  = row_nxt;
          wr_blk  = w_blk_r;
          chg_nxt = chg_all;
        end
        if (step_r == rows_eff + SW'(1)) begin
          step_nxt = '0;
          per_nxt  = per_r - PERIOD_W'(1);
          // a period that changes nothing is a fixed point
          if (per_r == PERIOD_W'(1) || !chg_all) begin
            state_nxt = ST_EMIT;
          end
        end else begin
          step_nxt = step_r + SW'(1);
        end
      end

      ST_EMIT: begin
        if (step_r != '0) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = RW'(step_r - SW'(1));
          out_inf_nxt   = rd_inf_n;
          out_blk_nxt   = rd_blk_n;
          out_last_nxt  = step_r == rows_eff;
          wr_en         = 1'b1;
          wr_addr       = RW'(step_r - SW'(1));
          wr_inf        = rd_inf_n;
          wr_blk        = rd_blk_n;
        end
        if (step_r == rows_eff) begin
          state_nxt = ST_IDLE;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + SW'(1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      per_r       <= '0;
      chg_r       <= 1'b0;
      lp_r        <= '0;
      out_valid_r <= 1'b0;
      grid_rows_r <= GRID_ROWS_RST;
      grid_cols_r <= GRID_COLS_RST;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      per_r       <= per_nxt;
      chg_r       <= chg_nxt;
      lp_r        <= lp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GRID_ROWS: grid_rows_r <= cfg_data;
          REG_GRID_COLS: grid_cols_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    w_prev_r   <= w_prev_nxt;
    w_mid_r    <= w_mid_nxt;
    w_blk_r    <= w_blk_nxt;
    out_last_r <= out_last_nxt;
    out_row_r  <= out_row_nxt;
    out_inf_r  <= out_inf_nxt;
    out_blk_r  <= out_blk_nxt;
  end

  assign busy                 = state_r != ST_IDLE;
  assign cfg_ready            = 1'b1;
  assign out_valid            = out_valid_r;
  assign out_last_row         = out_last_r;
  assign out_row_number       = ROW_NUM_W'(out_row_r);
  assign out_row_infected_out = ROW_W'(out_inf_r);
  assign out_row_blocked_out  = ROW_W'(out_blk_r);

endmodule

// ----- sv/gbs_checker.sv -----
// Port-level checks for the blocked-grid spread core, bound to the top level.
module gbs_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           in_req_type,
  input logic                           out_valid,
  input logic [gbs_pkg::ROW_NUM_W-1:0]  out_row_number,
  input logic                           out_last_row
);
  import gbs_pkg::*;

  // a run transfer always makes the block busy
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_req_type == REQ_RUN |=> busy)
    else $error("run accepted but busy not raised");

  // rows come out only while a run is under way
  a_out_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result row outside a run");

  // rows of a run come out on consecutive cycles in ascending order
  a_row_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_row |=>
      out_valid && out_row_number == $past(out_row_number) + ROW_NUM_W'(1))
    else $error("result rows not contiguous");

  // the first row of a run is row zero
  a_first_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid) |-> out_row_number == '0)
    else $error("run did not start at row zero");

  // the block is idle again when the last row is shown
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_row |-> !busy)
    else $error("still busy at last row");

endmodule

bind grid_blocked_spread_step_core gbs_checker u_gbs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_req_type    (in_req_type),
  .out_valid      (out_valid),
  .out_row_number (out_row_number),
  .out_last_row   (out_last_row)
);
